>>> rtl/ictf_pkg.sv
// ictf_pkg: shared types, constants and helper functions for the tilt filter
// no dependencies; used by every rtl file of the block
package ictf_pkg;

    // field and datapath widths
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MCAND_W   = 34;
    localparam int MPLIER_W  = 26;
    localparam int ACC_W     = 56;
    localparam int RND_W     = 40;
    localparam int SQ_W      = 48;
    localparam int CRD_W     = 48;
    localparam int AXES      = 3;
    localparam int ATAN_LEN  = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    // gyro scale 0.00875 deg/s per lsb in q0.32
    localparam logic [MPLIER_W-1:0] GYRO_SCALE = 26'd37580964;
    localparam logic [16:0]         ONE_Q16    = 17'h10000;

    // register reset values
    localparam logic [IN_W-1:0] OFS_X_RST  = 16'd74;
    localparam logic [IN_W-1:0] OFS_Y_RST  = 16'hFFAA;
    localparam logic [IN_W-1:0] OFS_Z_RST  = 16'd100;
    localparam logic [IN_W-1:0] WEIGHT_RST = 16'd6554;
    localparam logic [IN_W-1:0] TRUST_RST  = 16'd62259;
    localparam logic [IN_W-1:0] PERIOD_RST = 16'd5898;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFS_X  = 3'd0,
        CFG_OFS_Y  = 3'd1,
        CFG_OFS_Z  = 3'd2,
        CFG_WEIGHT = 3'd3,
        CFG_TRUST  = 3'd4,
        CFG_PERIOD = 3'd5
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_MUL0,
        S_ACC_MUL1,
        S_ACC_STORE,
        S_SQ_MUL,
        S_SQ_STORE,
        S_TILT_START,
        S_TILT_WAIT,
        S_GYR_MUL,
        S_GYR_STORE,
        S_RATE_MUL0,
        S_RATE_MUL1,
        S_RATE_STORE,
        S_INT_MUL,
        S_INT_STORE,
        S_FUS_MUL0,
        S_FUS_MUL1,
        S_FUS_STORE,
        S_MAC_WAIT,
        S_OUT
    } ictf_state_t;

    // tilt unit states
    typedef enum logic [1:0] {
        T_IDLE,
        T_SQRT,
        T_SETUP,
        T_CORDIC
    } tilt_state_t;

    // command to the serial multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic clear;
    } mac_cmd_t;

    // add one half and floor by 2^16
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v + 56'sd32768;
        return s[ACC_W-1:16];
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        hi = 40'sh007FFFFFFF;
        lo = -40'sh0080000000;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[OUT_W-1:0];
    endfunction

    // arctangent table, q16.16 degrees scaled by 180/3.14
    function automatic logic [22:0] atan_entry(input logic [4:0] i);
        case (i)
            5'd0:    return 23'd2950616;
            5'd1:    return 23'd1741850;
            5'd2:    return 23'd920346;
            5'd3:    return 23'd467182;
            5'd4:    return 23'd234498;
            5'd5:    return 23'd117363;
            5'd6:    return 23'd58696;
            5'd7:    return 23'd29350;
            5'd8:    return 23'd14675;
            5'd9:    return 23'd7338;
            5'd10:   return 23'd3669;
            5'd11:   return 23'd1834;
            5'd12:   return 23'd917;
            5'd13:   return 23'd459;
            5'd14:   return 23'd229;
            5'd15:   return 23'd115;
            5'd16:   return 23'd57;
            5'd17:   return 23'd29;
            5'd18:   return 23'd14;
            5'd19:   return 23'd7;
            5'd20:   return 23'd4;
            5'd21:   return 23'd2;
            5'd22:   return 23'd1;
            default: return 23'd0;
        endcase
    endfunction

endpackage

>>> rtl/ictf_ifs.sv
// ictf channel interfaces: sample input, result output, register writes
// depends on ictf_pkg for field widths
interface ictf_sample_if;
    import ictf_pkg::*;
    logic valid;
    logic ready;
    logic [IN_W-1:0] accel_x;
    logic [IN_W-1:0] accel_y;
    logic [IN_W-1:0] accel_z;
    logic [IN_W-1:0] gyro_ch0;
    logic [IN_W-1:0] gyro_ch1;
    logic [IN_W-1:0] gyro_ch2;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_ch0, gyro_ch1, gyro_ch2,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_ch0, gyro_ch1, gyro_ch2,
                  output ready);
endinterface

interface ictf_result_if;
    import ictf_pkg::*;
    logic valid;
    logic ready;
    logic [OUT_W-1:0] rate_x;
    logic [OUT_W-1:0] rate_y;
    logic [OUT_W-1:0] rate_z;
    logic [OUT_W-1:0] angle_x;
    logic [OUT_W-1:0] angle_y;
    logic [OUT_W-1:0] angle_z;
    modport source (output valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                    input ready);
    modport sink (input valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                  output ready);
endinterface

interface ictf_cfg_if;
    import ictf_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [IN_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ictf_serial_mac.sv
// ictf_serial_mac: bit-serial signed multiply-accumulate, one multiplier bit a cycle
// depends on ictf_pkg
module ictf_serial_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ictf_pkg::mac_cmd_t                    cmd,
    input  logic signed [ictf_pkg::MCAND_W-1:0]   mcand,
    input  logic [ictf_pkg::MPLIER_W-1:0]         mplier,
    output logic                                  busy,
    output logic signed [ictf_pkg::ACC_W-1:0]     acc
);
    import ictf_pkg::*;

    logic                    busy_reg, busy_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [MPLIER_W-1:0]     mplier_reg, mplier_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // shift-add step, stops once no multiplier bits remain
    always_comb
    begin
        busy_next   = busy_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (cmd.start)
        begin
            busy_next   = 1'b1;
            mcand_next  = ACC_W'(mcand);
            mplier_next = mplier;
            if (cmd.clear)
                acc_next = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
                busy_next = 1'b0;
            else
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

>>> rtl/ictf_tilt_unit.sv
// ictf_tilt_unit: integer square root (one result bit a cycle) then vectoring cordic
// depends on ictf_pkg
module ictf_tilt_unit #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ictf_pkg::OUT_W-1:0]  axis_val,
    input  logic [ictf_pkg::SQ_W-1:0]          sum_sq,
    output logic                               busy,
    output logic signed [ictf_pkg::OUT_W-1:0]  angle
);
    import ictf_pkg::*;

    localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int CNT_W     = $clog2(ATAN_LEN + 1);
    localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 2);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS_EFF - 1);

    tilt_state_t             state_reg, state_next;
    logic [SQ_W-1:0]         rem_reg, rem_next;
    logic [SQ_W-1:0]         root_reg, root_next;
    logic [SQ_W-1:0]         bit_reg, bit_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [OUT_W-1:0] a_reg, a_next;
    logic signed [CRD_W-1:0] x_reg, x_next;
    logic signed [CRD_W-1:0] y_reg, y_next;
    logic signed [OUT_W-1:0] z_reg, z_next;

    logic [SQ_W-1:0]         trial;
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
    logic signed [OUT_W-1:0] step_ang;

    assign trial    = root_reg + bit_reg;
    assign dx       = y_reg >>> cnt_reg[4:0];
    assign dy       = x_reg >>> cnt_reg[4:0];
    assign step_ang = OUT_W'(atan_entry(cnt_reg[4:0]));

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    rem_next   = sum_sq;
                    root_next  = '0;
                    bit_next   = BIT_TOP;
                    a_next     = axis_val;
                    state_next = T_SQRT;
                end
            end
            T_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = T_SETUP;
            end
            T_SETUP:
            begin
                x_next   = {root_reg[CRD_W-17:0], 16'h0000};
                y_next   = {a_reg, 16'h0000};
                z_next   = '0;
                cnt_next = '0;
                // zero vector gives zero angle
                if (a_reg == '0 && root_reg == '0)
                    state_next = T_IDLE;
                else
                    state_next = T_CORDIC;
            end
            T_CORDIC:
            begin
                if (!y_reg[CRD_W-1])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + step_ang;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - step_ang;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = T_IDLE;
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign busy  = (state_reg != T_IDLE);
    assign angle = z_reg;

endmodule

>>> rtl/imu_complementary_tilt_filter_core.sv
// imu_complementary_tilt_filter_core: top level, sequencer, state and register file
// depends on ictf_pkg, ictf_ifs, ictf_serial_mac, ictf_tilt_unit
//
// One raw imu sample per beat in, one result beat out. The block works on one
// sample at a time: it smooths the accelerations, forms three tilt angles with a
// square root and a vectoring cordic, scales and smooths the gyro rates and blends
// them into the fused angles. All 27 products go through one bit-serial
// multiply-accumulate unit that takes one multiplier bit per cycle up to its
// highest set bit; each tilt angle takes a 24-bit square root, a setup step
// and CORDIC_STEPS (at most 32) cordic steps. The time from one input beat
// to the next is set mostly by the multiply unit. A new sample is taken while
// the previous result still waits in the output register.
module imu_complementary_tilt_filter_core #(
    parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ictf_sample_if.sink  sample,
    ictf_result_if.source result,
    ictf_cfg_if.sink     cfg
);
    import ictf_pkg::*;

    localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

    // sequencer
    ictf_state_t state_reg, state_next;
    ictf_state_t ret_reg, ret_next;
    logic [1:0]  axis_reg, axis_next;

    // configuration
    logic [IN_W-1:0] ofs_reg [AXES];
    logic [IN_W-1:0] weight_reg;
    logic [IN_W-1:0] trust_reg;
    logic [IN_W-1:0] period_reg;

    // latched sample, gyro reordered to x, y, z
    logic [IN_W-1:0] accel_reg [AXES];
    logic [IN_W-1:0] gyro_reg [AXES];

    // filter state and scratch
    logic signed [OUT_W-1:0]   sacc_reg [AXES];
    logic signed [OUT_W-1:0]   srate_reg [AXES];
    logic signed [OUT_W-1:0]   fused_reg [AXES];
    logic signed [OUT_W-1:0]   tilt_reg [AXES];
    logic [SQ_W-1:0]           sq_reg [AXES];
    logic signed [MCAND_W-1:0] tmp_reg;

    // output register
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_rate_reg [AXES];
    logic [OUT_W-1:0]     out_angle_reg [AXES];

    // unit connections
    mac_cmd_t                mac_cmd;
    logic signed [MCAND_W-1:0] mac_mcand;
    logic [MPLIER_W-1:0]     mac_mplier;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    tilt_start;
    logic signed [OUT_W-1:0] tilt_a;
    logic [SQ_W-1:0]         tilt_n;
    logic                    tilt_busy;
    logic signed [OUT_W-1:0] tilt_z;

    // derived operands
    logic [MPLIER_W-1:0]       w_c;
    logic [MPLIER_W-1:0]       t_c;
    logic signed [OUT_W-1:0]   sacc_cur;
    logic [OUT_W-1:0]          sacc_abs;
    logic signed [16:0]        gyro_d;
    logic signed [RND_W-1:0]   mac_rnd;
    logic                      sample_beat;
    logic                      load_out;

    assign w_c      = MPLIER_W'(ONE_Q16 - {1'b0, weight_reg});
    assign t_c      = MPLIER_W'(ONE_Q16 - {1'b0, trust_reg});
    assign sacc_cur = sacc_reg[axis_reg];
    assign sacc_abs = sacc_cur[OUT_W-1] ? OUT_W'(-sacc_cur) : sacc_cur;
    assign gyro_d   = signed'({gyro_reg[axis_reg][IN_W-1], gyro_reg[axis_reg]})
                      - signed'({ofs_reg[axis_reg][IN_W-1], ofs_reg[axis_reg]});
    assign mac_rnd  = rnd16(mac_acc);

    assign sample_beat  = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign load_out     = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // tilt operand selection: one acceleration over the magnitude of the other two; tilt 0 uses y, tilt 1 uses x
    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                tilt_a = sacc_reg[1];
                tilt_n = sq_reg[0] + sq_reg[2];
            end
            2'd1:
            begin
                tilt_a = sacc_reg[0];
                tilt_n = sq_reg[1] + sq_reg[2];
            end
            default:
            begin
                tilt_a = sacc_reg[2];
                tilt_n = sq_reg[1] + sq_reg[0];
            end
        endcase
    end

    // next state and unit commands
    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        axis_next   = axis_reg;
        mac_cmd     = '0;
        mac_mcand   = '0;
        mac_mplier  = '0;
        tilt_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                axis_next = '0;
                if (sample_beat)
                    state_next = S_ACC_MUL0;
            end
            S_ACC_MUL0:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = {{10{accel_reg[axis_reg][IN_W-1]}}, accel_reg[axis_reg], 8'h00};
                mac_mplier = MPLIER_W'(weight_reg);
                ret_next   = S_ACC_MUL1;
                state_next = S_MAC_WAIT;
            end
            S_ACC_MUL1:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b0};
                mac_mcand  = MCAND_W'(sacc_cur);
                mac_mplier = w_c;
                ret_next   = S_ACC_STORE;
                state_next = S_MAC_WAIT;
            end
            S_ACC_STORE:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_SQ_MUL;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_ACC_MUL0;
                end
            end
            S_SQ_MUL:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = MCAND_W'(sacc_abs);
                mac_mplier = sacc_abs[MPLIER_W-1:0];
                ret_next   = S_SQ_STORE;
                state_next = S_MAC_WAIT;
            end
            S_SQ_STORE:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_TILT_START;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_SQ_MUL;
                end
            end
            S_TILT_START:
            begin
                tilt_start = 1'b1;
                state_next = S_TILT_WAIT;
            end
            S_TILT_WAIT:
            begin
                if (!tilt_busy)
                begin
                    if (axis_reg == LAST_AXIS)
                    begin
                        axis_next  = '0;
                        state_next = S_GYR_MUL;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_TILT_START;
                    end
                end
            end
            S_GYR_MUL:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = MCAND_W'(gyro_d);
                mac_mplier = GYRO_SCALE;
                ret_next   = S_GYR_STORE;
                state_next = S_MAC_WAIT;
            end
            S_GYR_STORE:
                state_next = S_RATE_MUL0;
            S_RATE_MUL0:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = tmp_reg;
                mac_mplier = MPLIER_W'(weight_reg);
                ret_next   = S_RATE_MUL1;
                state_next = S_MAC_WAIT;
            end
            S_RATE_MUL1:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b0};
                mac_mcand  = MCAND_W'(srate_reg[axis_reg]);
                mac_mplier = w_c;
                ret_next   = S_RATE_STORE;
                state_next = S_MAC_WAIT;
            end
            S_RATE_STORE:
                state_next = S_INT_MUL;
            S_INT_MUL:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = MCAND_W'(srate_reg[axis_reg]);
                mac_mplier = MPLIER_W'(period_reg);
                ret_next   = S_INT_STORE;
                state_next = S_MAC_WAIT;
            end
            S_INT_STORE:
                state_next = S_FUS_MUL0;
            S_FUS_MUL0:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b1};
                mac_mcand  = tmp_reg;
                mac_mplier = MPLIER_W'(trust_reg);
                ret_next   = S_FUS_MUL1;
                state_next = S_MAC_WAIT;
            end
            S_FUS_MUL1:
            begin
                mac_cmd    = '{start: 1'b1, clear: 1'b0};
                mac_mcand  = MCAND_W'(tilt_reg[axis_reg]);
                mac_mplier = t_c;
                ret_next   = S_FUS_STORE;
                state_next = S_MAC_WAIT;
            end
            S_FUS_STORE:
            begin
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_GYR_MUL;
                end
            end
            S_MAC_WAIT:
            begin
                if (!mac_busy)
                    state_next = ret_reg;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            axis_reg  <= axis_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_reg[0] <= OFS_X_RST;
            ofs_reg[1] <= OFS_Y_RST;
            ofs_reg[2] <= OFS_Z_RST;
            weight_reg <= WEIGHT_RST;
            trust_reg  <= TRUST_RST;
            period_reg <= PERIOD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_OFS_X:  ofs_reg[0] <= cfg.data;
                CFG_OFS_Y:  ofs_reg[1] <= cfg.data;
                CFG_OFS_Z:  ofs_reg[2] <= cfg.data;
                CFG_WEIGHT: weight_reg <= cfg.data;
                CFG_TRUST:  trust_reg  <= cfg.data;
                CFG_PERIOD: period_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    // filter state, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                sacc_reg[i]  <= '0;
                srate_reg[i] <= '0;
                fused_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_ACC_STORE:  sacc_reg[axis_reg]  <= mac_rnd[OUT_W-1:0];
                S_RATE_STORE: srate_reg[axis_reg] <= mac_rnd[OUT_W-1:0];
                S_FUS_STORE:  fused_reg[axis_reg] <= sat32(mac_rnd);
                default:      ;
            endcase
        end
    end

    // sample latch and scratch values
    always_ff @(posedge clk)
    begin
        if (sample_beat)
        begin
            accel_reg[0] <= sample.accel_x;
            accel_reg[1] <= sample.accel_y;
            accel_reg[2] <= sample.accel_z;
            gyro_reg[0]  <= sample.gyro_ch1;
            gyro_reg[1]  <= sample.gyro_ch2;
            gyro_reg[2]  <= sample.gyro_ch0;
        end
        case (state_reg)
            S_SQ_STORE:  sq_reg[axis_reg] <= mac_acc[SQ_W-1:0];
            S_TILT_WAIT:
            begin
                if (!tilt_busy)
                    tilt_reg[axis_reg] <= tilt_z;
            end
            S_GYR_STORE: tmp_reg <= mac_rnd[MCAND_W-1:0];
            S_INT_STORE: tmp_reg <= MCAND_W'(fused_reg[axis_reg]) + mac_rnd[MCAND_W-1:0];
            default:     ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                out_rate_reg[i]  <= srate_reg[i];
                out_angle_reg[i] <= fused_reg[i];
            end
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.rate_x  = out_rate_reg[0];
    assign result.rate_y  = out_rate_reg[1];
    assign result.rate_z  = out_rate_reg[2];
    assign result.angle_x = out_angle_reg[0];
    assign result.angle_y = out_angle_reg[1];
    assign result.angle_z = out_angle_reg[2];

    // shared multiply-accumulate
    ictf_serial_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .busy   (mac_busy),
        .acc    (mac_acc)
    );

    // square root and cordic
    ictf_tilt_unit #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_tilt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tilt_start),
        .axis_val (tilt_a),
        .sum_sq   (tilt_n),
        .busy     (tilt_busy),
        .angle    (tilt_z)
    );

endmodule
